// ===== design/octree_morton_cell_index_defines.svh =====
// assertion helpers for the asserting design file
`ifndef OCTREE_MORTON_CELL_INDEX_DEFINES_SVH
`define OCTREE_MORTON_CELL_INDEX_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define OMCI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("omci assertion failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define OMCI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("omci assertion failed");

`endif

// ===== design/omci_pkg.sv =====
package omci_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned IndexW  = 22;
  localparam int unsigned DepthW  = 3;

  // one bit at every multiple of three: sum of 8^i
  localparam logic [IndexW-1:0] LevelOffsetMask = 22'h249249;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_LEVEL,
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_SCALE_Z
  } omci_reg_e;

  typedef struct packed {
    logic signed [WordW-1:0] lo_x;
    logic signed [WordW-1:0] lo_y;
    logic signed [WordW-1:0] lo_z;
    logic signed [WordW-1:0] hi_x;
    logic signed [WordW-1:0] hi_y;
    logic signed [WordW-1:0] hi_z;
  } omci_box_t;

  typedef struct packed {
    logic [IndexW-1:0] cell_index;
    logic [DepthW-1:0] cell_depth;
    logic              valid_res;
  } omci_cell_t;

  // load enables of the per-coordinate stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } omci_stage_en_t;

  // (8^depth - 1) / 7
  function automatic logic [IndexW-1:0] lvl_offset(input logic [DepthW-1:0] depth);
    logic [4:0] sh;
    sh = 5'(depth) * 5'd3;
    return LevelOffsetMask & ((22'd1 << sh) - 22'd1);
  endfunction

endpackage

// ===== design/omci_if.sv =====
interface omci_box_if;
  logic                valid;
  logic                ready;
  omci_pkg::omci_box_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface omci_cell_if;
  logic                 valid;
  logic                 ready;
  omci_pkg::omci_cell_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/omci_coord.sv =====
module omci_coord (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  omci_pkg::omci_stage_en_t       en_i,
  input  logic [omci_pkg::WordW-1:0]     pos_i,
  input  logic [omci_pkg::WordW-1:0]     origin_i,
  input  logic [omci_pkg::WordW-1:0]     scale_i,
  output logic [omci_pkg::WordW-1:0]     q_o,
  output logic                           neg_o
);
  import omci_pkg::*;

  localparam int unsigned HalfW = WordW / 2;
  localparam int unsigned PpW   = WordW + HalfW;

  logic [WordW:0]   diff;
  logic [WordW-1:0] mag_d, mag_q;
  logic             neg1_q, neg2_q, neg3_q;
  logic [PpW-1:0]   pp_lo_q, pp_hi_q;
  logic [2*WordW-1:0] prod;
  logic [WordW-1:0] q_q;

  // exact 33-bit difference, magnitude fits 32 bits
  assign diff  = {pos_i[WordW-1], pos_i} - {origin_i[WordW-1], origin_i};
  assign mag_d = diff[WordW] ? WordW'((WordW+1)'(0) - diff) : diff[WordW-1:0];

  // split product: two 32x16 partial products
  assign prod = {HalfW'(0), pp_lo_q} + {pp_hi_q, HalfW'(0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= '0;
      neg1_q  <= 1'b0;
      pp_lo_q <= '0;
      pp_hi_q <= '0;
      neg2_q  <= 1'b0;
      q_q     <= '0;
      neg3_q  <= 1'b0;
    end else begin
      if (en_i.s1) begin
        mag_q  <= mag_d;
        neg1_q <= diff[WordW];
      end
      if (en_i.s2) begin
        pp_lo_q <= PpW'(mag_q) * PpW'(scale_i[HalfW-1:0]);
        pp_hi_q <= PpW'(mag_q) * PpW'(scale_i[WordW-1:HalfW]);
        neg2_q  <= neg1_q;
      end
      if (en_i.s3) begin
        q_q    <= prod[2*WordW-1:WordW];
        neg3_q <= neg2_q;
      end
    end
  end

  assign q_o   = q_q;
  assign neg_o = neg3_q;

endmodule

// ===== design/octree_morton_cell_index.sv =====
// linear octree cell index of a box, morton order
// throughput: one word per cycle; the pipeline only holds when the output stalls
// the multiply is split into two 32x16 partial products over two stages
// reset clears the stage valid bits and loads grid_level 0, origin 0, scale 1.0
`include "octree_morton_cell_index_defines.svh"

module octree_morton_cell_index #(
  parameter int unsigned LEVEL_LIMIT = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [omci_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [omci_pkg::WordW-1:0]      cfg_wdata_i,
  omci_box_if.sink                        box_i,
  omci_cell_if.source                     cell_o
);
  import omci_pkg::*;

  localparam int unsigned MaxLevel = (LEVEL_LIMIT - 1 < 7) ? LEVEL_LIMIT - 1 : 7;
  localparam int unsigned CellW    = MaxLevel;
  localparam int unsigned CodeW    = 3 * MaxLevel;

  // configuration
  logic [DepthW-1:0] grid_level_q;
  logic [WordW-1:0]  origin_q [3];
  logic [WordW-1:0]  scale_q  [3];
  logic [DepthW-1:0] lvl_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_level_q <= '0;
      for (int a = 0; a < 3; a++) begin
        origin_q[a] <= '0;
        scale_q[a]  <= 32'h0001_0000;
      end
    end else if (cfg_we_i) begin
      case (omci_reg_e'(cfg_idx_i))
        REG_GRID_LEVEL: grid_level_q <= cfg_wdata_i[DepthW-1:0];
        REG_ORIGIN_X:   origin_q[0]  <= cfg_wdata_i;
        REG_ORIGIN_Y:   origin_q[1]  <= cfg_wdata_i;
        REG_ORIGIN_Z:   origin_q[2]  <= cfg_wdata_i;
        REG_SCALE_X:    scale_q[0]   <= cfg_wdata_i;
        REG_SCALE_Y:    scale_q[1]   <= cfg_wdata_i;
        REG_SCALE_Z:    scale_q[2]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign lvl_eff = (grid_level_q > DepthW'(MaxLevel)) ? DepthW'(MaxLevel) : grid_level_q;

  // stage valid bits and load enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;
  omci_stage_en_t coord_en;

  assign en5 = !v5_q || cell_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign box_i.ready = en1;
  assign coord_en = '{s1: en1, s2: en2, s3: en3};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= box_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // stages 1 to 3: one coordinate unit per corner and axis, lo x y z then hi x y z
  logic [WordW-1:0] pos_w [6];
  logic [WordW-1:0] q_w   [6];
  logic             neg_w [6];

  assign pos_w[0] = box_i.data.lo_x;
  assign pos_w[1] = box_i.data.lo_y;
  assign pos_w[2] = box_i.data.lo_z;
  assign pos_w[3] = box_i.data.hi_x;
  assign pos_w[4] = box_i.data.hi_y;
  assign pos_w[5] = box_i.data.hi_z;

  for (genvar k = 0; k < 6; k++) begin : g_coord
    omci_coord u_coord (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (coord_en),
      .pos_i    (pos_w[k]),
      .origin_i (origin_q[k % 3]),
      .scale_i  (scale_q[k % 3]),
      .q_o      (q_w[k]),
      .neg_o    (neg_w[k])
    );
  end

  // stage 4: grid check and bit interleave
  logic [5:0]       in_grid;
  logic [CodeW-1:0] code_lo_d, code_hi_d, code_lo_q, code_hi_q;
  logic             ok4_q;

  always_comb begin
    code_lo_d = '0;
    code_hi_d = '0;
    for (int k = 0; k < 6; k++) begin
      // a value in (-1, 0) truncates to cell 0 and still counts as inside
      in_grid[k] = !(neg_w[k] && (q_w[k] != '0)) && ((q_w[k] >> lvl_eff) == '0);
    end
    for (int i = 0; i < CellW; i++) begin
      for (int a = 0; a < 3; a++) begin
        code_lo_d[3*i+a] = q_w[a][i];
        code_hi_d[3*i+a] = q_w[3+a][i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      code_lo_q <= code_lo_d;
      code_hi_q <= code_hi_d;
      ok4_q     <= &in_grid;
    end
  end

  // stage 5: coarsest differing group, level offset and shifted code
  logic [CodeW-1:0]  dif;
  logic [DepthW-1:0] up;
  logic [DepthW-1:0] depth;
  logic [4:0]        up_sh;
  omci_cell_t        res_d, res_q;

  always_comb begin
    dif = code_lo_q ^ code_hi_q;
    up  = '0;
    for (int i = 0; i < MaxLevel; i++) begin
      if (dif[3*i +: 3] != 3'b000) up = DepthW'(i + 1);
    end
    depth = lvl_eff - up;
    up_sh = 5'(up) * 5'd3;
    res_d = '0;
    if (ok4_q) begin
      res_d.cell_index = lvl_offset(depth) + (IndexW'(code_hi_q) >> up_sh);
      res_d.cell_depth = depth;
      res_d.valid_res  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) res_q <= res_d;
  end

  assign cell_o.valid = v5_q;
  assign cell_o.data  = res_q;

  `OMCI_ASSERT_NOW(a_invalid_zero, cell_o.valid && !cell_o.data.valid_res, (cell_o.data.cell_index == '0) && (cell_o.data.cell_depth == '0))
  `OMCI_ASSERT_NOW(a_depth_bound, cell_o.valid, cell_o.data.cell_depth <= lvl_eff)
  `OMCI_ASSERT_NEXT(a_accept_enters, box_i.valid && box_i.ready, v1_q)

endmodule
